FILE: rtl/wmlp_pkg.sv
// Shared types and constants of the WebAssembly memory limit parser.
package wmlp_pkg;

  localparam logic [31:0] HeaderBytes       = 32'd8;
  localparam logic [7:0]  MemorySectionId   = 8'd5;
  localparam logic [6:0]  UlebShiftStep     = 7'd7;
  localparam logic [6:0]  UlebShiftLimit    = 7'd64;
  localparam logic [31:0] ModuleLengthReset = 32'd8;
  localparam logic [16:0] PageLimitReset    = 17'd256;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CfgModuleLength = 2'd0;
  localparam cfg_idx_t CfgPageLimit    = 2'd1;

  localparam logic [1:0] VerdictAccepted   = 2'd0;
  localparam logic [1:0] VerdictInitialOver = 2'd1;
  localparam logic [1:0] VerdictNoMaximum  = 2'd2;
  localparam logic [1:0] VerdictMaximumOver = 2'd3;

  typedef enum logic [3:0] {
    PhHeader  = 4'd0,
    PhId      = 4'd1,
    PhSize    = 4'd2,
    PhSkip    = 4'd3,
    PhCount   = 4'd4,
    PhFlags   = 4'd5,
    PhInitial = 4'd6,
    PhMaximum = 4'd7,
    PhDone    = 4'd8
  } phase_e;

  typedef struct packed {
    logic [31:0] module_length;
    logic [16:0] page_limit;
  } cfg_t;

  typedef struct packed {
    logic        memory_found;
    logic [63:0] init_pages;
    logic        maximum_present;
    logic [63:0] max_pages;
    logic [1:0]  verdict;
  } result_t;

endpackage

FILE: rtl/wmlp_cfg_regs.sv
// Configuration register file: module length and page limit.
module wmlp_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  wmlp_pkg::cfg_idx_t  cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  output wmlp_pkg::cfg_t      cfg_o
);

  logic [31:0] module_length_q;
  logic [16:0] page_limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      module_length_q <= wmlp_pkg::ModuleLengthReset;
      page_limit_q    <= wmlp_pkg::PageLimitReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        wmlp_pkg::CfgModuleLength: module_length_q <= cfg_data_i;
        wmlp_pkg::CfgPageLimit:    page_limit_q    <= cfg_data_i[16:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  assign cfg_o.module_length = module_length_q;
  assign cfg_o.page_limit    = page_limit_q;

endmodule

FILE: rtl/wmlp_parser.sv
// Per-byte section walker with ULEB128 decoding and the end-of-module report.
module wmlp_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          data_byte_i,
  input  wmlp_pkg::cfg_t      cfg_i,
  output logic                hit_o,
  output wmlp_pkg::result_t   result_o
);

  logic [31:0]      pos_q, pos_d;
  wmlp_pkg::phase_e phase_q, phase_d;
  logic [63:0]      acc_q, acc_d;
  logic [6:0]       shift_q, shift_d;
  logic             is_mem_q, is_mem_d;
  logic [31:0]      pend_q, pend_d;
  logic             flag_max_q, flag_max_d;
  logic [63:0]      init_q, init_d;
  logic [63:0]      max_q, max_d;
  logic             has_init_q, has_init_d;
  logic             has_max_q, has_max_d;

  logic [31:0] next;
  logic [31:0] left;
  logic [31:0] sec_end;
  logic [63:0] acc_fed;
  logic        uleb_fail;
  logic        uleb_done;
  logic [63:0] init_rep;
  logic [63:0] max_rep;
  logic [63:0] limit_ext;

  assign next  = pos_q + 32'd1;
  assign hit_o = (next == cfg_i.module_length);

  always_comb begin
    uleb_fail   = (shift_q >= wmlp_pkg::UlebShiftLimit);
    uleb_done   = !data_byte_i[7];
    acc_fed     = acc_q | (64'(data_byte_i[6:0]) << shift_q);
    left        = (next <= cfg_i.module_length) ? (cfg_i.module_length - next) : 32'd0;
    sec_end     = next + acc_fed[31:0];

    pos_d      = next;
    phase_d    = phase_q;
    acc_d      = acc_q;
    shift_d    = shift_q;
    is_mem_d   = is_mem_q;
    pend_d     = pend_q;
    flag_max_d = flag_max_q;
    init_d     = init_q;
    max_d      = max_q;
    has_init_d = has_init_q;
    has_max_d  = has_max_q;

    case (phase_q)
      wmlp_pkg::PhHeader: begin
        if (next >= wmlp_pkg::HeaderBytes) phase_d = wmlp_pkg::PhId;
      end
      wmlp_pkg::PhId: begin
        is_mem_d = (data_byte_i == wmlp_pkg::MemorySectionId);
        acc_d    = '0;
        shift_d  = '0;
        phase_d  = wmlp_pkg::PhSize;
      end
      wmlp_pkg::PhSize: begin
        if (uleb_fail) begin
          phase_d = wmlp_pkg::PhDone;
        end else begin
          acc_d = acc_fed;
          if (!uleb_done) begin
            shift_d = shift_q + wmlp_pkg::UlebShiftStep;
          end else if (acc_fed > {32'd0, left}) begin
            phase_d = wmlp_pkg::PhDone;  // section runs past the module end
          end else begin
            pend_d = sec_end;
            if (is_mem_q) begin
              acc_d   = '0;
              shift_d = '0;
              phase_d = wmlp_pkg::PhCount;
            end else if (sec_end == next) begin
              phase_d = wmlp_pkg::PhId;
            end else begin
              phase_d = wmlp_pkg::PhSkip;
            end
          end
        end
      end
      wmlp_pkg::PhSkip: begin
        if (next >= pend_q) phase_d = wmlp_pkg::PhId;
      end
      wmlp_pkg::PhCount: begin
        if (uleb_fail) begin
          phase_d = wmlp_pkg::PhDone;
        end else begin
          acc_d = acc_fed;
          if (!uleb_done) begin
            shift_d = shift_q + wmlp_pkg::UlebShiftStep;
          end else if (acc_fed == 64'd0 || next >= pend_q) begin
            phase_d = wmlp_pkg::PhDone;
          end else begin
            phase_d = wmlp_pkg::PhFlags;
          end
        end
      end
      wmlp_pkg::PhFlags: begin
        flag_max_d = data_byte_i[0];
        acc_d      = '0;
        shift_d    = '0;
        phase_d    = wmlp_pkg::PhInitial;
      end
      wmlp_pkg::PhInitial: begin
        if (uleb_fail) begin
          phase_d = wmlp_pkg::PhDone;
        end else begin
          acc_d = acc_fed;
          if (!uleb_done) begin
            shift_d = shift_q + wmlp_pkg::UlebShiftStep;
          end else begin
            init_d     = acc_fed;
            has_init_d = 1'b1;
            if (flag_max_q) begin
              acc_d   = '0;
              shift_d = '0;
              phase_d = wmlp_pkg::PhMaximum;
            end else begin
              phase_d = wmlp_pkg::PhDone;
            end
          end
        end
      end
      wmlp_pkg::PhMaximum: begin
        if (uleb_fail) begin
          phase_d = wmlp_pkg::PhDone;
        end else begin
          acc_d = acc_fed;
          if (!uleb_done) begin
            shift_d = shift_q + wmlp_pkg::UlebShiftStep;
          end else begin
            max_d     = acc_fed;
            has_max_d = 1'b1;
            phase_d   = wmlp_pkg::PhDone;
          end
        end
      end
      default: ;  // stopped: only count bytes
    endcase

    // Report from the state this byte leaves behind.
    init_rep  = has_init_d ? init_d : 64'd0;
    max_rep   = has_max_d ? max_d : 64'd0;
    limit_ext = {47'd0, cfg_i.page_limit};

    result_o.memory_found    = has_init_d;
    result_o.init_pages      = init_rep;
    result_o.maximum_present = has_max_d;
    result_o.max_pages       = max_rep;
    if (init_rep > limit_ext) begin
      result_o.verdict = wmlp_pkg::VerdictInitialOver;
    end else if (has_init_d && !has_max_d) begin
      result_o.verdict = wmlp_pkg::VerdictNoMaximum;
    end else if (has_max_d && max_rep > limit_ext) begin
      result_o.verdict = wmlp_pkg::VerdictMaximumOver;
    end else begin
      result_o.verdict = wmlp_pkg::VerdictAccepted;
    end

    // Last byte of the module: start over for the next one.
    if (hit_o) begin
      pos_d      = '0;
      phase_d    = wmlp_pkg::PhHeader;
      acc_d      = '0;
      shift_d    = '0;
      is_mem_d   = 1'b0;
      pend_d     = '0;
      flag_max_d = 1'b0;
      init_d     = '0;
      max_d      = '0;
      has_init_d = 1'b0;
      has_max_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      phase_q    <= wmlp_pkg::PhHeader;
      acc_q      <= '0;
      shift_q    <= '0;
      is_mem_q   <= 1'b0;
      pend_q     <= '0;
      flag_max_q <= 1'b0;
      init_q     <= '0;
      max_q      <= '0;
      has_init_q <= 1'b0;
      has_max_q  <= 1'b0;
    end else if (step_i) begin
      pos_q      <= pos_d;
      phase_q    <= phase_d;
      acc_q      <= acc_d;
      shift_q    <= shift_d;
      is_mem_q   <= is_mem_d;
      pend_q     <= pend_d;
      flag_max_q <= flag_max_d;
      init_q     <= init_d;
      max_q      <= max_d;
      has_init_q <= has_init_d;
      has_max_q  <= has_max_d;
    end
  end

  a_restart_after_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && hit_o |=> phase_q == wmlp_pkg::PhHeader && pos_q == 32'd0)
    else $error("parser did not restart after the report");

  a_max_needs_initial: assert property (@(posedge clk_i) disable iff (!rst_ni)
    has_max_q |-> has_init_q)
    else $error("maximum recorded without initial pages");

  a_shift_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift_q <= (wmlp_pkg::UlebShiftLimit + wmlp_pkg::UlebShiftStep - 7'd1))
    else $error("ULEB shift advanced past the failure point");

endmodule

FILE: rtl/wmlp_out_reg.sv
// Result register with valid/ready handshake toward the consumer.
module wmlp_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  wmlp_pkg::result_t  result_i,
  output logic               free_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output wmlp_pkg::result_t  result_o
);

  logic              valid_q;
  wmlp_pkg::result_t result_q;

  assign free_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

FILE: rtl/wasm_memory_limit_parser_core.sv
// Top level of the WebAssembly memory limit parser.
//
// Streams a WebAssembly module in one byte per request on the input channel,
// skips the 8-byte header, walks the sections and decodes the memory section
// (count, flags, initial pages and, when flag bit 0 is set, maximum pages).
// On the byte whose running count equals module_length it issues one result
// request carrying what was found and a verdict against page_limit; every
// other byte produces nothing. Throughput is one byte per cycle: each byte is
// captured in an input register and then advanced through one pass of the
// section walker into the result register, which then offers the result
// after its final byte is taken. The only stall comes from the result
// register: a final byte waits in the input register, and the input stalls,
// while an earlier result is still unclaimed; bytes that do not end a module
// keep flowing while that result waits. Write configuration (index 0
// module_length, index 1 page_limit) only while no bytes are in flight;
// writes to other indexes are dropped.
module wasm_memory_limit_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte stream
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  // result
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        memory_found_o,
  output logic [63:0] initial_pages_o,
  output logic        maximum_present_o,
  output logic [63:0] maximum_pages_o,
  output logic [1:0]  verdict_o,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  wmlp_pkg::cfg_t    cfg;
  wmlp_pkg::result_t step_result;
  wmlp_pkg::result_t out_result;

  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       hit;
  logic       out_free;
  logic       step;

  wmlp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Advance the held byte unless it ends the module and the result slot is busy.
  assign step       = in_valid_q && (!hit || out_free);
  assign in_ready_o = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Hold the byte until the walker takes it.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= data_byte_i;
    end
  end

  wmlp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .data_byte_i (byte_q),
    .cfg_i       (cfg),
    .hit_o       (hit),
    .result_o    (step_result)
  );

  wmlp_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step && hit),
    .result_i    (step_result),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (out_result)
  );

  assign memory_found_o    = out_result.memory_found;
  assign initial_pages_o   = out_result.init_pages;
  assign maximum_present_o = out_result.maximum_present;
  assign maximum_pages_o   = out_result.max_pages;
  assign verdict_o         = out_result.verdict;

endmodule
